// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the translator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is off while reset is held.
`define SAT_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that also runs through reset.
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/sat_pkg.sv -----
// Package for the segment address translator: defaults, codes and shared types.
// Depends on nothing; used by sat_match and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    // Default sizes
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_ADDR_BITS   = 32;

    // Fixed field widths
    localparam int ACTIVE_W = 5;
    localparam int SLOT_W   = 4;
    localparam int FIELD_W  = 32;

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_XLATE = 1'b1;

    // Tag that rides with each table read through the match pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

    // One result word
    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] virt_addr;
        logic [FIELD_W-1:0] file_offset;
        logic [FIELD_W-1:0] bytes_left;
        logic [SLOT_W-1:0]  hit_slot;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/sat_table.sv -----
// Mapping table: one synchronous RAM, one write port, one registered read port.
// Depends on nothing; instantiated by segment_address_translator_core.
`timescale 1ns / 1ps
`default_nettype none

module sat_table #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int DATA_W = 96
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read into an output register
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/sat_match.sv -----
// Two-stage entry matcher: distance into the mapping, then range test and outputs.
// Depends on sat_pkg; instantiated by segment_address_translator_core.
`timescale 1ns / 1ps
`default_nettype none

module sat_match #(
    parameter int ADDR_BITS = 32,
    parameter int IDX_W     = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   flush,
    input  wire sat_pkg::scan_tag_t     in_tag,
    input  wire logic [IDX_W-1:0]       in_slot,
    input  wire logic [3*ADDR_BITS-1:0] in_entry,
    input  wire logic [ADDR_BITS-1:0]   query,
    input  wire logic                   query_is_offset,
    output sat_pkg::scan_tag_t          out_tag,
    output logic      [IDX_W-1:0]       out_slot,
    output logic                        out_hit,
    output logic      [ADDR_BITS-1:0]   out_vaddr,
    output logic      [ADDR_BITS-1:0]   out_foff,
    output logic      [ADDR_BITS-1:0]   out_left
);

    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] off;
    logic [ADDR_BITS-1:0] len;
    logic [ADDR_BITS-1:0] origin;

    sat_pkg::scan_tag_t   tag_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [ADDR_BITS-1:0] dist_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [ADDR_BITS-1:0] off_reg;
    logic [ADDR_BITS-1:0] len_reg;

    // Unpack the entry and pick the origin by query kind
    assign base   = in_entry[3*ADDR_BITS-1:2*ADDR_BITS];
    assign off    = in_entry[2*ADDR_BITS-1:ADDR_BITS];
    assign len    = in_entry[ADDR_BITS-1:0];
    assign origin = query_is_offset ? off : base;

    // Stage one: tag, drop on flush
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg.valid <= in_tag.valid && !flush;
            tag_reg.last  <= in_tag.last;
        end
    end

    // Stage one: distance and entry fields
    always_ff @(posedge aclk) begin
        slot_reg <= in_slot;
        dist_reg <= query - origin;
        base_reg <= base;
        off_reg  <= off;
        len_reg  <= len;
    end

    // Stage two: range test and translated values
    assign out_tag   = tag_reg;
    assign out_slot  = slot_reg;
    assign out_hit   = dist_reg < len_reg;
    assign out_vaddr = base_reg + dist_reg;
    assign out_foff  = off_reg + dist_reg;
    assign out_left  = len_reg - dist_reg;

endmodule

`default_nettype wire

// ----- hdl/segment_address_translator_core.sv -----
// Segment address translator top level: scan sequencer, hint, result buffer.
// Depends on sat_pkg, sat_table, sat_match and assert_macros.svh.
//
//  channel | direction | handshake          | word
//  s_      | in        | s_valid / s_ready  | func, entry_index, entry_*, query, query_is_offset
//  m_      | out       | m_valid / m_ready  | found, virt_addr, file_offset, bytes_left, hit_slot
//  cfg_    | in        | cfg_valid/cfg_ready| active_count
//
// A load word writes the table in its accept cycle and is done.
// A translate word tests the hint entry, if held, then entries 0 .. count-1, one table
// read per cycle, and stops at the first hit; the matched result passes the table read
// register and the match register before it is registered in the result buffer.
// The single table read port sets the scan rate. With no hint and a zero count
// the not-found result is registered in the accept cycle.
// Two result registers hold finished words while m_ready is low; s_ready drops
// only while a scan runs or both are full. Synchronous active-low reset clears
// the hint, the count and all valid state; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module segment_address_translator_core #(
    parameter int MAX_ENTRIES = sat_pkg::DEF_MAX_ENTRIES,
    parameter int ADDR_BITS   = sat_pkg::DEF_ADDR_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sat_pkg::ACTIVE_W-1:0]  cfg_active_count,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [sat_pkg::SLOT_W-1:0]    s_entry_index,
    input  wire logic [sat_pkg::FIELD_W-1:0]   s_entry_vaddr,
    input  wire logic [sat_pkg::FIELD_W-1:0]   s_entry_fileoff,
    input  wire logic [sat_pkg::FIELD_W-1:0]   s_entry_length,
    input  wire logic [sat_pkg::FIELD_W-1:0]   s_query,
    input  wire logic                          s_query_is_offset,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic      [sat_pkg::FIELD_W-1:0]   m_virt_addr,
    output logic      [sat_pkg::FIELD_W-1:0]   m_file_offset,
    output logic      [sat_pkg::FIELD_W-1:0]   m_bytes_left,
    output logic      [sat_pkg::SLOT_W-1:0]    m_hit_slot
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = 3 * ADDR_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [sat_pkg::ACTIVE_W-1:0]   count_reg;
    logic                           hint_valid_reg, hint_valid_next;
    logic [IDX_W-1:0]               hint_slot_reg, hint_slot_next;
    logic                           issuing_reg, issuing_next;
    logic                           use_hint_reg, use_hint_next;
    logic [CNT_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]               lim_reg, lim_next;
    logic [ADDR_BITS-1:0]           q_reg, q_next;
    logic                           is_off_reg, is_off_next;
    sat_pkg::scan_tag_t             tag0_reg;
    logic [IDX_W-1:0]               slot0_reg;

    logic                           out_valid_reg, out_valid_next;
    sat_pkg::result_t               out_res_reg, out_res_next;
    logic                           pend_valid_reg, pend_valid_next;
    sat_pkg::result_t               pend_res_reg, pend_res_next;

    logic                           s_accept;
    logic                           wr_en;
    logic                           wr_in_range;
    logic [IDX_W-1:0]               wr_addr;
    logic [DATA_W-1:0]              wr_data;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic [DATA_W-1:0]              rd_data;
    sat_pkg::scan_tag_t             rd_tag;
    logic [15:0]                    count_ext;
    logic [15:0]                    lim_calc;
    logic [CNT_W-1:0]               scan_inc;
    logic                           empty_done;
    logic                           finish;

    sat_pkg::scan_tag_t             mt_tag;
    logic [IDX_W-1:0]               mt_slot;
    logic                           mt_hit;
    logic [ADDR_BITS-1:0]           mt_vaddr;
    logic [ADDR_BITS-1:0]           mt_foff;
    logic [ADDR_BITS-1:0]           mt_left;

    logic                           res_valid;
    sat_pkg::result_t               res_new;
    logic                           out_take;
    logic                           out_free;

    // Configuration: always ready; the user must write it only while idle (not enforced here)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            count_reg <= cfg_active_count;
        end
    end

    // Input handshake
    assign s_ready  = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign s_accept = s_valid && s_ready;

    // Table write path: drop writes to slots past the table
    assign wr_in_range = 16'(s_entry_index) < 16'(MAX_ENTRIES);
    assign wr_addr     = IDX_W'(s_entry_index);
    assign wr_data     = {ADDR_BITS'(s_entry_vaddr), ADDR_BITS'(s_entry_fileoff),
                          ADDR_BITS'(s_entry_length)};

    // Saturate the entry count at the table size
    assign count_ext = 16'(count_reg);
    assign lim_calc  = (count_ext > 16'(MAX_ENTRIES)) ? 16'(MAX_ENTRIES) : count_ext;
    assign scan_inc  = scan_idx_reg + CNT_W'(1);

    // A word is done when the matcher reports a hit or the last entry
    assign finish = mt_tag.valid && (mt_hit || mt_tag.last);

    // Sequencer: accept, issue reads, retire
    always_comb begin
        state_next      = state_reg;
        hint_valid_next = hint_valid_reg;
        hint_slot_next  = hint_slot_reg;
        issuing_next    = issuing_reg;
        use_hint_next   = use_hint_reg;
        scan_idx_next   = scan_idx_reg;
        lim_next        = lim_reg;
        q_next          = q_reg;
        is_off_next     = is_off_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = hint_slot_reg;
        rd_tag          = '0;
        empty_done      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_func == sat_pkg::FUNC_LOAD) begin
                        wr_en           = wr_in_range;
                        hint_valid_next = 1'b0;
                        hint_slot_next  = '0;
                    end else begin
                        q_next        = ADDR_BITS'(s_query);
                        is_off_next   = s_query_is_offset;
                        lim_next      = lim_calc[CNT_W-1:0];
                        scan_idx_next = '0;
                        use_hint_next = hint_valid_reg;
                        if (!hint_valid_reg && (lim_calc == 16'd0)) begin
                            empty_done = 1'b1;
                        end else begin
                            issuing_next = 1'b1;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    issuing_next = 1'b0;
                    state_next   = ST_IDLE;
                    if (mt_hit) begin
                        hint_valid_next = 1'b1;
                        hint_slot_next  = mt_slot;
                    end
                end else if (issuing_reg) begin
                    rd_en        = 1'b1;
                    rd_tag.valid = 1'b1;
                    if (use_hint_reg) begin
                        rd_addr       = hint_slot_reg;
                        rd_tag.last   = (lim_reg == '0);
                        use_hint_next = 1'b0;
                    end else begin
                        rd_addr       = scan_idx_reg[IDX_W-1:0];
                        rd_tag.last   = (scan_inc == lim_reg);
                        scan_idx_next = scan_inc;
                    end
                    if (rd_tag.last) begin
                        issuing_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hint_valid_reg <= 1'b0;
            hint_slot_reg  <= '0;
            issuing_reg    <= 1'b0;
            use_hint_reg   <= 1'b0;
            scan_idx_reg   <= '0;
            lim_reg        <= '0;
            tag0_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            hint_valid_reg <= hint_valid_next;
            hint_slot_reg  <= hint_slot_next;
            issuing_reg    <= issuing_next;
            use_hint_reg   <= use_hint_next;
            scan_idx_reg   <= scan_idx_next;
            lim_reg        <= lim_next;
            tag0_reg       <= rd_tag;
        end
    end

    // Query and read slot, aligned with the table output
    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        is_off_reg <= is_off_next;
        slot0_reg  <= rd_addr;
    end

    sat_table #(
        .DEPTH  (MAX_ENTRIES),
        .IDX_W  (IDX_W),
        .DATA_W (DATA_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sat_match #(
        .ADDR_BITS (ADDR_BITS),
        .IDX_W     (IDX_W)
    ) u_match (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .flush           (finish),
        .in_tag          (tag0_reg),
        .in_slot         (slot0_reg),
        .in_entry        (rd_data),
        .query           (q_reg),
        .query_is_offset (is_off_reg),
        .out_tag         (mt_tag),
        .out_slot        (mt_slot),
        .out_hit         (mt_hit),
        .out_vaddr       (mt_vaddr),
        .out_foff        (mt_foff),
        .out_left        (mt_left)
    );

    // Form the result word; a miss reads as all zero
    assign res_valid = empty_done || finish;

    always_comb begin
        res_new = '0;
        if (finish && mt_hit) begin
            res_new.found       = 1'b1;
            res_new.virt_addr   = sat_pkg::FIELD_W'(mt_vaddr);
            res_new.file_offset = sat_pkg::FIELD_W'(mt_foff);
            res_new.bytes_left  = sat_pkg::FIELD_W'(mt_left);
            res_new.hit_slot    = sat_pkg::SLOT_W'(mt_slot);
        end
    end

    // Two-deep result buffer: output register plus one pending word
    assign out_take = out_valid_reg && m_ready;
    assign out_free = !out_valid_reg || out_take;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (pend_valid_reg && out_free) begin
            out_res_next    = pend_res_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end else if (res_valid && out_free) begin
            out_res_next   = res_new;
            out_valid_next = 1'b1;
        end else if (res_valid) begin
            pend_res_next   = res_new;
            pend_valid_next = 1'b1;
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    // Output ports
    assign m_valid       = out_valid_reg;
    assign m_found       = out_res_reg.found;
    assign m_virt_addr   = out_res_reg.virt_addr;
    assign m_file_offset = out_res_reg.file_offset;
    assign m_bytes_left  = out_res_reg.bytes_left;
    assign m_hit_slot    = out_res_reg.hit_slot;

    // Checks
    `SAT_ASSERT_RST(a_pend_behind_out, aclk, aresetn, pend_valid_reg |-> out_valid_reg, "pending word without output word")
    `SAT_ASSERT_RST(a_no_overrun, aclk, aresetn, res_valid |-> !pend_valid_reg, "result while both result registers full")
    `SAT_ASSERT_RST(a_match_in_scan, aclk, aresetn, mt_tag.valid |-> (state_reg == ST_SCAN), "match output outside a scan")
    `SAT_ASSERT_RST(a_hint_in_table, aclk, aresetn, hint_valid_reg |-> (16'(hint_slot_reg) < 16'(MAX_ENTRIES)), "hint slot past table")
    `SAT_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for segment_address_translator_core: random and directed load/translate words.
// Depends on sat_pkg and the translator RTL; predicts each translate result in-line.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = sat_pkg::DEF_MAX_ENTRIES;

    // One input word as the sender holds it
    typedef struct {
        logic                        func;
        logic [sat_pkg::SLOT_W-1:0]  slot;
        logic [sat_pkg::FIELD_W-1:0] vaddr;
        logic [sat_pkg::FIELD_W-1:0] fileoff;
        logic [sat_pkg::FIELD_W-1:0] span;
        logic [sat_pkg::FIELD_W-1:0] query;
        logic                        by_off;
    } xlate_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sat_pkg::ACTIVE_W-1:0]  cfg_active_count = '0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_func = sat_pkg::FUNC_LOAD;
    logic [sat_pkg::SLOT_W-1:0]    s_entry_index = '0;
    logic [sat_pkg::FIELD_W-1:0]   s_entry_vaddr = '0;
    logic [sat_pkg::FIELD_W-1:0]   s_entry_fileoff = '0;
    logic [sat_pkg::FIELD_W-1:0]   s_entry_length = '0;
    logic [sat_pkg::FIELD_W-1:0]   s_query = '0;
    logic                          s_query_is_offset = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_found;
    logic [sat_pkg::FIELD_W-1:0]   m_virt_addr;
    logic [sat_pkg::FIELD_W-1:0]   m_file_offset;
    logic [sat_pkg::FIELD_W-1:0]   m_bytes_left;
    logic [sat_pkg::SLOT_W-1:0]    m_hit_slot;

    segment_address_translator_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_active_count  (cfg_active_count),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_entry_index     (s_entry_index),
        .s_entry_vaddr     (s_entry_vaddr),
        .s_entry_fileoff   (s_entry_fileoff),
        .s_entry_length    (s_entry_length),
        .s_query           (s_query),
        .s_query_is_offset (s_query_is_offset),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_virt_addr       (m_virt_addr),
        .m_file_offset     (m_file_offset),
        .m_bytes_left      (m_bytes_left),
        .m_hit_slot        (m_hit_slot)
    );

    // Words waiting for the sender, translate results waiting for the receiver
    xlate_word_t       queued_words [$];
    sat_pkg::result_t  predicted_xlates [$];
    int                mismatch_count = 0;

    // Predictor state: segment map, last-hit hint, scan count
    logic [sat_pkg::FIELD_W-1:0] map_vbase [SLOTS];
    logic [sat_pkg::FIELD_W-1:0] map_foff  [SLOTS];
    logic [sat_pkg::FIELD_W-1:0] map_span  [SLOTS];
    logic [sat_pkg::SLOT_W-1:0]  hint_slot = '0;
    logic                        hint_live = 1'b0;
    logic [sat_pkg::ACTIVE_W-1:0] scan_count = '0;

    // Stimulus-side copy of what has been queued for loading
    logic [sat_pkg::FIELD_W-1:0] plan_vbase [SLOTS];
    logic [sat_pkg::FIELD_W-1:0] plan_foff  [SLOTS];
    logic [sat_pkg::FIELD_W-1:0] plan_span  [SLOTS];

    int phase_counts [8] = '{16, 5, 31, 0, 1, 17, 10, 16};

    // Handshake flags and idle counters
    logic        s_took = 1'b0;
    logic        m_took = 1'b0;
    int          tx_wait = 0;
    int          rx_wait = 0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    xlate_word_t tx_word;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Test whether a slot covers the query, distance taken mod 2^32
    function automatic logic slot_covers(input logic [sat_pkg::SLOT_W-1:0] slot,
                                         input logic [sat_pkg::FIELD_W-1:0] q,
                                         input logic by_off);
        logic [sat_pkg::FIELD_W-1:0] gap;
        gap = q - (by_off ? map_foff[slot] : map_vbase[slot]);
        return gap < map_span[slot];
    endfunction

    // Build the hit result and move the hint to this slot
    function automatic sat_pkg::result_t take_hit(input logic [sat_pkg::SLOT_W-1:0] slot,
                                                  input logic [sat_pkg::FIELD_W-1:0] q,
                                                  input logic by_off);
        sat_pkg::result_t r;
        logic [sat_pkg::FIELD_W-1:0] gap;
        gap = q - (by_off ? map_foff[slot] : map_vbase[slot]);
        r.found       = 1'b1;
        r.virt_addr   = map_vbase[slot] + gap;
        r.file_offset = map_foff[slot] + gap;
        r.bytes_left  = map_span[slot] - gap;
        r.hit_slot    = slot;
        hint_slot = slot;
        hint_live = 1'b1;
        return r;
    endfunction

    // Hint first, then slots below the saturated count in order
    function automatic sat_pkg::result_t translate_query(input logic [sat_pkg::FIELD_W-1:0] q,
                                                         input logic by_off);
        int limit;
        limit = (scan_count > SLOTS) ? SLOTS : int'(scan_count);
        if (hint_live && slot_covers(hint_slot, q, by_off)) begin
            return take_hit(hint_slot, q, by_off);
        end
        for (int i = 0; i < limit; i++) begin
            if (slot_covers(4'(i), q, by_off)) begin
                return take_hit(4'(i), q, by_off);
            end
        end
        return '0;
    endfunction

    function automatic void check_result(input sat_pkg::result_t want,
                                         input sat_pkg::result_t got);
        if (got.found !== want.found) begin
            mismatch_count++;
            $error("found: expected %0h, got %0h", want.found, got.found);
        end
        if (got.virt_addr !== want.virt_addr) begin
            mismatch_count++;
            $error("virt_addr: expected %08h, got %08h", want.virt_addr, got.virt_addr);
        end
        if (got.file_offset !== want.file_offset) begin
            mismatch_count++;
            $error("file_offset: expected %08h, got %08h", want.file_offset, got.file_offset);
        end
        if (got.bytes_left !== want.bytes_left) begin
            mismatch_count++;
            $error("bytes_left: expected %08h, got %08h", want.bytes_left, got.bytes_left);
        end
        if (got.hit_slot !== want.hit_slot) begin
            mismatch_count++;
            $error("hit_slot: expected %0d, got %0d", want.hit_slot, got.hit_slot);
        end
    endfunction

    // Sample both channels; predict on each accepted word, check each result word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took     <= 1'b0;
            m_took     <= 1'b0;
            hint_live  = 1'b0;
            hint_slot  = '0;
            scan_count = '0;
        end else begin
            s_took <= s_valid && s_ready;
            m_took <= m_valid && m_ready;
            if (cfg_valid && cfg_ready) begin
                scan_count = cfg_active_count;
            end
            if (s_valid && s_ready) begin
                if (s_func == sat_pkg::FUNC_LOAD) begin
                    map_vbase[s_entry_index] = s_entry_vaddr;
                    map_foff[s_entry_index]  = s_entry_fileoff;
                    map_span[s_entry_index]  = s_entry_length;
                    hint_live = 1'b0;
                    hint_slot = '0;
                end else begin
                    predicted_xlates.push_back(translate_query(s_query, s_query_is_offset));
                end
            end
            if (m_valid && m_ready) begin
                if (predicted_xlates.size() == 0) begin
                    mismatch_count++;
                    $error("result word with no translate pending (found %0h, slot %0d)",
                           m_found, m_hit_slot);
                end else begin
                    check_result(predicted_xlates.pop_front(),
                                 {m_found, m_virt_addr, m_file_offset, m_bytes_left,
                                  m_hit_slot});
                end
            end
        end
    end

    // Sender: hold a word until taken, then idle a drawn number of cycles
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (tx_wait != 0) begin
                tx_wait--;
                s_valid <= 1'b0;
            end else if (queued_words.size() != 0) begin
                tx_word = queued_words.pop_front();
                s_func            <= tx_word.func;
                s_entry_index     <= tx_word.slot;
                s_entry_vaddr     <= tx_word.vaddr;
                s_entry_fileoff   <= tx_word.fileoff;
                s_entry_length    <= tx_word.span;
                s_query           <= tx_word.query;
                s_query_is_offset <= tx_word.by_off;
                s_valid           <= 1'b1;
                if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall a drawn number of cycles after each result word
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_took) begin
                if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
            end
            if (rx_wait != 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_load(input logic [sat_pkg::SLOT_W-1:0] slot,
                             input logic [sat_pkg::FIELD_W-1:0] va,
                             input logic [sat_pkg::FIELD_W-1:0] fo,
                             input logic [sat_pkg::FIELD_W-1:0] span);
        xlate_word_t w;
        w.func    = sat_pkg::FUNC_LOAD;
        w.slot    = slot;
        w.vaddr   = va;
        w.fileoff = fo;
        w.span    = span;
        w.query   = $urandom;
        w.by_off  = 1'($urandom_range(0, 1));
        plan_vbase[slot] = va;
        plan_foff[slot]  = fo;
        plan_span[slot]  = span;
        queued_words.push_back(w);
    endtask

    task automatic push_query(input logic [sat_pkg::FIELD_W-1:0] q, input logic by_off);
        xlate_word_t w;
        w.func    = sat_pkg::FUNC_XLATE;
        w.slot    = sat_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
        w.vaddr   = $urandom;
        w.fileoff = $urandom;
        w.span    = $urandom;
        w.query   = q;
        w.by_off  = by_off;
        queued_words.push_back(w);
    endtask

    // Hold off until every word is sent and every result is back, then let the scan settle
    task automatic wait_idle();
        while (queued_words.size() != 0 || s_valid || predicted_xlates.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (SLOTS + 8) @(posedge aclk);
        #1;
    endtask

    task automatic write_count(input logic [sat_pkg::ACTIVE_W-1:0] n);
        @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_active_count <= n;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        #1;
    endtask

    // Mostly queries aimed at loaded segments, some reloads and some raw noise
    task automatic random_phase(input int n_words, input int count);
        int reach;
        int pick;
        logic [sat_pkg::SLOT_W-1:0]  slot;
        logic [sat_pkg::FIELD_W-1:0] span;
        logic [sat_pkg::FIELD_W-1:0] gap;
        logic [sat_pkg::FIELD_W-1:0] va;
        logic by_off;
        reach = (count > SLOTS) ? SLOTS : count;
        slot = '0;
        repeat (n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                case ($urandom_range(0, 7))
                    0: span = '0;
                    1: span = $urandom;
                    2: span = '1;
                    default: span = $urandom_range(1, 'h1000);
                endcase
                va = ($urandom_range(0, 5) == 0) ? 32'hFFFF_F800 + $urandom_range(0, 'h7FF)
                                                : $urandom;
                push_load(sat_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)), va, $urandom, span);
            end else if (pick < 85) begin
                // reuse the last slot now and then so the hint gets hit
                if (pick >= 45) begin
                    if (reach > 0 && $urandom_range(0, 3) != 0) begin
                        slot = sat_pkg::SLOT_W'($urandom_range(0, reach - 1));
                    end else begin
                        slot = sat_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
                    end
                end
                span = plan_span[slot];
                by_off = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: gap = '0;
                    1: gap = span - 1;
                    2: gap = span;
                    default: gap = (span == 0) ? '0 : $urandom % span;
                endcase
                push_query((by_off ? plan_foff[slot] : plan_vbase[slot]) + gap, by_off);
            end else begin
                push_query($urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Reset, directed words, then random phases under varying scan counts
    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        // no hint and zero count: not found without touching the map
        push_query('0, 1'b0);
        for (int i = 0; i < 13; i++) begin
            push_load(4'(i), 32'h1000_0000 + i * 32'h1_0000, i * 32'h1000, 32'h1000);
        end
        // wrapping segment, empty segment at all-ones, near-full-range segment
        push_load(4'd13, 32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h200);
        push_load(4'd14, '1, '1, '0);
        push_load(4'd15, 32'h4000_0000, 32'h4000_0000, '1);
        wait_idle();

        write_count(5'd16);
        push_query(32'h1000_0000, 1'b0);
        push_query(32'h0000_3FFF, 1'b1);
        push_query(32'h1003_1000, 1'b0);
        push_query(32'h3FFF_FFFF, 1'b0);
        push_query(32'hFFFF_FFFF, 1'b1);
        push_query(32'h0000_0050, 1'b0);
        wait_idle();

        // hinted slot stays live after the count shrinks below it
        write_count(5'd2);
        push_query(32'h0000_0060, 1'b0);
        push_query(32'h1001_0010, 1'b0);
        wait_idle();

        // count above the map size saturates
        write_count(5'd31);
        push_query(32'h3FFF_FFFF, 1'b0);
        push_query(32'h7000_0000, 1'b1);
        wait_idle();

        foreach (phase_counts[p]) begin
            write_count(5'(phase_counts[p]));
            random_phase(100, phase_counts[p]);
            wait_idle();
        end

        if (mismatch_count == 0 && predicted_xlates.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
